### rtl/ream_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ream_pkg
// Shared widths, codes, types and helper functions for the reference element
// affine map.
// ----------------------------------------------------------------------------
package ream_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DEN_W     = PROD_W + 1;
  localparam int NUM_W     = DEN_W + FRAC_BITS;
  localparam int QB        = COORD_W + 2;
  localparam int LIM_W     = DEN_W + QB;
  localparam int FIN_W     = NUM_W + 2;
  localparam int NMUL      = 6;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [2:0] KIND_TRI  = 3'd3;
  localparam logic [2:0] KIND_RECT = 3'd4;
  localparam logic       CMD_G2L   = 1'b0;
  localparam logic       CMD_L2G   = 1'b1;

  localparam logic signed [FIN_W-1:0] ONE_FIN = FIN_W'(1) <<< FRAC_BITS;
  localparam logic signed [FIN_W-1:0] SAT_MAX = (FIN_W'(1) <<< (COORD_W - 1)) - FIN_W'(1);
  localparam logic signed [FIN_W-1:0] SAT_MIN = -(FIN_W'(1) <<< (COORD_W - 1));

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_DEGEN   = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  // One classified transaction, handed from the front end to the divider.
  typedef struct packed {
    logic                       bypass;
    status_t                    bstat;
    logic                       div;
    logic                       sub_one;
    logic signed [NUM_W-1:0]    num_x;
    logic signed [NUM_W-1:0]    num_y;
    logic signed [DEN_W-1:0]    den_x;
    logic signed [DEN_W-1:0]    den_y;
    logic signed [COORD_W-1:0]  pt_x;
    logic signed [COORD_W-1:0]  pt_y;
  } work_t;

  // One coordinate inside the long division pipeline.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] ud;
    logic [QB-1:0]    q;
    logic             qneg;
    logic             huge;
  } lane_t;

  typedef struct packed {
    logic                       bypass;
    status_t                    bstat;
    logic                       div;
    logic                       sub_one;
    logic signed [COORD_W-1:0]  pt_x;
    logic signed [COORD_W-1:0]  pt_y;
    lane_t                      lx;
    lane_t                      ly;
  } stage_t;

  typedef struct packed {
    logic                       clip;
    logic signed [COORD_W-1:0]  v;
  } satv_t;

  // Set up a lane: magnitudes, quotient sign and the early overflow check.
  // A lane that needs no division keeps its value in rem and gets an
  // all-ones divisor so that no step ever subtracts.
  function automatic lane_t lane_init(logic signed [NUM_W-1:0] num,
                                      logic signed [DEN_W-1:0] den,
                                      logic div);
    lane_t            l;
    logic [NUM_W-1:0] un;
    logic [DEN_W-1:0] ud;
    logic [LIM_W-1:0] lim;
    un = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    ud = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    lim = {ud, {QB{1'b0}}};
    l.rem = un;
    l.q   = '0;
    if (div) begin
      l.ud   = ud;
      l.qneg = num[NUM_W-1] ^ den[DEN_W-1];
      l.huge = (LIM_W'(un) >= lim);
    end else begin
      l.ud   = '1;
      l.qneg = num[NUM_W-1];
      l.huge = 1'b0;
    end
    return l;
  endfunction

  // One restoring division step for quotient bit bitpos.
  function automatic lane_t div_step(lane_t l, int unsigned bitpos);
    lane_t            o;
    logic [LIM_W-1:0] sh;
    logic [LIM_W-1:0] r;
    o  = l;
    sh = LIM_W'(l.ud) << bitpos;
    r  = LIM_W'(l.rem);
    if (r >= sh) begin
      o.rem = l.rem - sh[NUM_W-1:0];
      o.q   = l.q | (QB'(1) << bitpos);
    end
    return o;
  endfunction

  // Apply the sign, the optional -1 offset and clamp to the coordinate range.
  function automatic satv_t lane_finish(lane_t l, logic div, logic sub_one);
    satv_t                   s;
    logic [NUM_W-1:0]        mag;
    logic signed [FIN_W-1:0] val;
    mag = div ? NUM_W'(l.q) : l.rem;
    val = FIN_W'(mag);
    if (l.qneg) val = -val;
    if (sub_one) val = val - ONE_FIN;
    s.clip = 1'b1;
    if (l.huge) begin
      s.v = l.qneg ? SAT_MIN[COORD_W-1:0] : SAT_MAX[COORD_W-1:0];
    end else if (val > SAT_MAX) begin
      s.v = SAT_MAX[COORD_W-1:0];
    end else if (val < SAT_MIN) begin
      s.v = SAT_MIN[COORD_W-1:0];
    end else begin
      s.clip = 1'b0;
      s.v    = val[COORD_W-1:0];
    end
    return s;
  endfunction

endpackage

### rtl/ream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ream_in_if / ream_out_if
// Valid/ready channels for points in and mapped points out.
// ----------------------------------------------------------------------------
interface ream_in_if;
  import ream_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [2:0]                cell_kind;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] node0_x;
  logic signed [COORD_W-1:0] node0_y;
  logic signed [COORD_W-1:0] node1_x;
  logic signed [COORD_W-1:0] node1_y;
  logic signed [COORD_W-1:0] node2_x;
  logic signed [COORD_W-1:0] node2_y;
  logic signed [COORD_W-1:0] node3_y;

  modport source (output valid, cmd, cell_kind, point_x, point_y, node0_x, node0_y,
                  node1_x, node1_y, node2_x, node2_y, node3_y, input ready);
  modport sink   (input valid, cmd, cell_kind, point_x, point_y, node0_x, node0_y,
                  node1_x, node1_y, node2_x, node2_y, node3_y, output ready);
endinterface

interface ream_out_if;
  import ream_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] mapped_x;
  logic signed [COORD_W-1:0] mapped_y;
  logic [1:0]                status;

  modport source (output valid, mapped_x, mapped_y, status, input ready);
  modport sink   (input valid, mapped_x, mapped_y, status, output ready);
endinterface

### rtl/ream_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ream_front
// Accepts points, forms edge differences, runs the shared multipliers and
// classifies each transaction into a division job or a direct result.
// ----------------------------------------------------------------------------
module ream_front (
  input  logic                clk,
  input  logic                rst_n,
  ream_in_if.sink             in_ch,
  output logic                q_valid,
  output ream_pkg::work_t     q_data,
  input  logic                q_ready
);
  import ream_pkg::*;

  localparam logic signed [DIFF_W-1:0] ONE_D = DIFF_W'(1) <<< FRAC_BITS;

  logic en;

  // Stage 1 registers.
  logic                      f1_v_r;
  logic                      f1_tri_r, f1_rect_r, f1_cmd_r;
  logic signed [COORD_W-1:0] f1_px_r, f1_py_r, f1_x0_r, f1_y0_r;
  logic signed [DIFF_W-1:0]  f1_dx_r, f1_dy_r, f1_bx_r, f1_by_r;
  logic signed [DIFF_W-1:0]  f1_opa_r [NMUL];
  logic signed [DIFF_W-1:0]  f1_opb_r [NMUL];

  // Stage 2 registers.
  logic                      f2_v_r;
  logic                      f2_tri_r, f2_rect_r, f2_cmd_r;
  logic signed [COORD_W-1:0] f2_px_r, f2_py_r, f2_x0_r, f2_y0_r;
  logic signed [DIFF_W-1:0]  f2_dx_r, f2_dy_r, f2_bx_r, f2_by_r;
  logic signed [PROD_W-1:0]  f2_m_r [NMUL];

  // Stage 3 registers.
  logic  f3_v_r;
  work_t f3_w_r;
  work_t f3_w_nxt;

  logic signed [DIFF_W-1:0] a, b, c, d, dyr, bx, by, px1, py1, pxe, pye;
  logic signed [DIFF_W-1:0] opa [NMUL];
  logic signed [DIFF_W-1:0] opb [NMUL];
  logic                     is_tri, is_rect;

  assign en          = !f3_v_r || q_ready;
  assign in_ch.ready = en;
  assign q_valid     = f3_v_r;
  assign q_data      = f3_w_r;

  assign is_tri  = (in_ch.cell_kind == KIND_TRI);
  assign is_rect = (in_ch.cell_kind == KIND_RECT);
  assign pxe = DIFF_W'(in_ch.point_x);
  assign pye = DIFF_W'(in_ch.point_y);
  assign a   = DIFF_W'(in_ch.node1_x) - DIFF_W'(in_ch.node0_x);
  assign b   = DIFF_W'(in_ch.node2_x) - DIFF_W'(in_ch.node0_x);
  assign c   = DIFF_W'(in_ch.node1_y) - DIFF_W'(in_ch.node0_y);
  assign d   = DIFF_W'(in_ch.node2_y) - DIFF_W'(in_ch.node0_y);
  assign dyr = DIFF_W'(in_ch.node3_y) - DIFF_W'(in_ch.node0_y);
  assign bx  = pxe - DIFF_W'(in_ch.node0_x);
  assign by  = pye - DIFF_W'(in_ch.node0_y);
  assign px1 = pxe + ONE_D;
  assign py1 = pye + ONE_D;

  // Operand routing for the six shared multipliers.
  always_comb begin
    for (int i = 0; i < NMUL; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    if (is_tri && in_ch.cmd == CMD_G2L) begin
      opa[0] = a; opb[0] = d;
      opa[1] = b; opb[1] = c;
      opa[2] = d; opb[2] = bx;
      opa[3] = b; opb[3] = by;
      opa[4] = a; opb[4] = by;
      opa[5] = c; opb[5] = bx;
    end else if (is_tri) begin
      opa[2] = pxe; opb[2] = a;
      opa[3] = pye; opb[3] = b;
      opa[4] = pxe; opb[4] = c;
      opa[5] = pye; opb[5] = d;
    end else begin
      opa[2] = a;   opb[2] = px1;
      opa[4] = dyr; opb[4] = py1;
    end
  end

  // Combine products into numerators, determinant or direct results.
  always_comb begin
    logic signed [DEN_W-1:0] det, sx, sy;
    det = DEN_W'(f2_m_r[0]) - DEN_W'(f2_m_r[1]);
    sx  = '0;
    sy  = '0;
    f3_w_nxt         = '0;
    f3_w_nxt.pt_x    = f2_px_r;
    f3_w_nxt.pt_y    = f2_py_r;
    f3_w_nxt.bstat   = ST_OK;
    if (f2_tri_r && f2_cmd_r == CMD_G2L) begin
      sx = DEN_W'(f2_m_r[2]) - DEN_W'(f2_m_r[3]);
      sy = DEN_W'(f2_m_r[4]) - DEN_W'(f2_m_r[5]);
      f3_w_nxt.num_x = NUM_W'(sx) <<< FRAC_BITS;
      f3_w_nxt.num_y = NUM_W'(sy) <<< FRAC_BITS;
      f3_w_nxt.den_x = det;
      f3_w_nxt.den_y = det;
      f3_w_nxt.div   = 1'b1;
      if (det == '0) begin
        f3_w_nxt.bypass = 1'b1;
        f3_w_nxt.bstat  = ST_DEGEN;
      end
    end else if (f2_tri_r) begin
      sx = DEN_W'(f2_m_r[2]) + DEN_W'(f2_m_r[3]);
      sy = DEN_W'(f2_m_r[4]) + DEN_W'(f2_m_r[5]);
      f3_w_nxt.num_x = NUM_W'(f2_x0_r) + NUM_W'(sx >>> FRAC_BITS);
      f3_w_nxt.num_y = NUM_W'(f2_y0_r) + NUM_W'(sy >>> FRAC_BITS);
    end else if (f2_rect_r && f2_cmd_r == CMD_G2L) begin
      f3_w_nxt.num_x   = NUM_W'(f2_bx_r) <<< (FRAC_BITS + 1);
      f3_w_nxt.num_y   = NUM_W'(f2_by_r) <<< (FRAC_BITS + 1);
      f3_w_nxt.den_x   = DEN_W'(f2_dx_r);
      f3_w_nxt.den_y   = DEN_W'(f2_dy_r);
      f3_w_nxt.div     = 1'b1;
      f3_w_nxt.sub_one = 1'b1;
      if (f2_dx_r == '0 || f2_dy_r == '0) begin
        f3_w_nxt.bypass = 1'b1;
        f3_w_nxt.bstat  = ST_DEGEN;
      end
    end else if (f2_rect_r) begin
      f3_w_nxt.num_x = NUM_W'(f2_x0_r) + NUM_W'(f2_m_r[2] >>> (FRAC_BITS + 1));
      f3_w_nxt.num_y = NUM_W'(f2_y0_r) + NUM_W'(f2_m_r[4] >>> (FRAC_BITS + 1));
    end else begin
      f3_w_nxt.bypass = 1'b1;
      f3_w_nxt.bstat  = ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_ch.valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_tri_r  <= is_tri;
      f1_rect_r <= is_rect;
      f1_cmd_r  <= in_ch.cmd;
      f1_px_r   <= in_ch.point_x;
      f1_py_r   <= in_ch.point_y;
      f1_x0_r   <= in_ch.node0_x;
      f1_y0_r   <= in_ch.node0_y;
      f1_dx_r   <= a;
      f1_dy_r   <= dyr;
      f1_bx_r   <= bx;
      f1_by_r   <= by;
      for (int i = 0; i < NMUL; i++) begin
        f1_opa_r[i] <= opa[i];
        f1_opb_r[i] <= opb[i];
        f2_m_r[i]   <= f1_opa_r[i] * f1_opb_r[i];
      end
      f2_tri_r  <= f1_tri_r;
      f2_rect_r <= f1_rect_r;
      f2_cmd_r  <= f1_cmd_r;
      f2_px_r   <= f1_px_r;
      f2_py_r   <= f1_py_r;
      f2_x0_r   <= f1_x0_r;
      f2_y0_r   <= f1_y0_r;
      f2_dx_r   <= f1_dx_r;
      f2_dy_r   <= f1_dy_r;
      f2_bx_r   <= f1_bx_r;
      f2_by_r   <= f1_by_r;
      f3_w_r    <= f3_w_nxt;
    end
  end

endmodule

### rtl/ream_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ream_queue
// Small register queue that decouples the front end from the divider.
// ----------------------------------------------------------------------------
module ream_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  ream_pkg::work_t  push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output ream_pkg::work_t  pop_data,
  input  logic             pop_ready
);
  import ream_pkg::*;

  work_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

### rtl/ream_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ream_back
// Pipelined restoring divider, one quotient bit per stage for both
// coordinates, followed by sign, offset, saturation and the output register.
// ----------------------------------------------------------------------------
module ream_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             w_valid,
  input  ream_pkg::work_t  w_data,
  output logic             w_ready,
  ream_out_if.source       out_ch
);
  import ream_pkg::*;

  logic   en;
  logic   v_r  [QB+1];
  stage_t st_r [QB+1];
  stage_t st0_nxt;
  stage_t stn   [QB];

  logic                      out_v_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  status_t                   out_st_r;
  logic signed [COORD_W-1:0] res_x, res_y;
  status_t                   res_st;
  satv_t                     sx, sy;

  assign en      = !out_v_r || out_ch.ready;
  assign w_ready = en;

  always_comb begin
    st0_nxt.bypass  = w_data.bypass;
    st0_nxt.bstat   = w_data.bstat;
    st0_nxt.div     = w_data.div;
    st0_nxt.sub_one = w_data.sub_one;
    st0_nxt.pt_x    = w_data.pt_x;
    st0_nxt.pt_y    = w_data.pt_y;
    st0_nxt.lx      = lane_init(w_data.num_x, w_data.den_x, w_data.div);
    st0_nxt.ly      = lane_init(w_data.num_y, w_data.den_y, w_data.div);
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    always_comb begin
      stn[s]    = st_r[s];
      stn[s].lx = div_step(st_r[s].lx, QB - 1 - s);
      stn[s].ly = div_step(st_r[s].ly, QB - 1 - s);
    end
  end

  always_comb begin
    sx = lane_finish(st_r[QB].lx, st_r[QB].div, st_r[QB].sub_one);
    sy = lane_finish(st_r[QB].ly, st_r[QB].div, st_r[QB].sub_one);
    if (st_r[QB].bypass) begin
      res_x  = st_r[QB].pt_x;
      res_y  = st_r[QB].pt_y;
      res_st = st_r[QB].bstat;
    end else begin
      res_x  = sx.v;
      res_y  = sy.v;
      res_st = (sx.clip || sy.clip) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) v_r[i] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= w_valid;
      for (int i = 0; i < QB; i++) v_r[i+1] <= v_r[i];
      out_v_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_nxt;
      for (int i = 0; i < QB; i++) st_r[i+1] <= stn[i];
      out_x_r  <= res_x;
      out_y_r  <= res_y;
      out_st_r <= res_st;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.mapped_x = out_x_r;
  assign out_ch.mapped_y = out_y_r;
  assign out_ch.status   = out_st_r;

endmodule

### rtl/reference_element_affine_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reference_element_affine_map
// Maps 2D points between global coordinates and the reference element of a
// rectangle or triangle cell, in signed Q15.16 fixed point.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   in_ch     in         cmd, cell_kind, point, node coordinates
//   out_ch    out        mapped_x, mapped_y, status
//
// The block takes one transaction per cycle while its queue is not full.
// From input to output a point passes three front stages (differences,
// multipliers, combine), the queue, one setup stage, one stage per quotient
// bit of the divider (COORD_W + 2 of them) and the output register. The
// divider depth sets the latency; with no stall, one point leaves per cycle.
// Reset is synchronous and active low and clears only valid and queue state.
// A stall on the output freezes the back end only; the front end keeps
// accepting until the four-entry queue fills.
//
module reference_element_affine_map (
  input  logic        clk,
  input  logic        rst_n,
  ream_in_if.sink     in_ch,
  ream_out_if.source  out_ch
);
  import ream_pkg::*;

  // Front end to queue.
  logic  fq_valid, fq_ready;
  work_t fq_data;

  // Queue to divider back end.
  logic  qb_valid, qb_ready;
  work_t qb_data;

  // The front end forms differences and products and decides per
  // transaction whether the back end divides, passes a direct result
  // through, or simply returns the input point with a fixed status.
  ream_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_data  (fq_data),
    .q_ready (fq_ready)
  );

  // The queue lets the front end run while the output is stalled.
  ream_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_data  (fq_data),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_data   (qb_data),
    .pop_ready  (qb_ready)
  );

  // The back end runs the long division, applies sign and offset and
  // saturates to the coordinate range.
  ream_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .w_valid (qb_valid),
    .w_data  (qb_data),
    .w_ready (qb_ready),
    .out_ch  (out_ch)
  );

endmodule

### rtl/ream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ream_checker
// Port-level checks on the affine map: output handshake, transaction
// accounting and the saturation status.
// ----------------------------------------------------------------------------
module ream_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ream_pkg::COORD_W-1:0] out_mapped_x,
  input logic signed [ream_pkg::COORD_W-1:0] out_mapped_y,
  input logic [1:0]                         out_status
);
  import ream_pkg::*;

  localparam logic signed [COORD_W-1:0] CMAX = SAT_MAX[COORD_W-1:0];
  localparam logic signed [COORD_W-1:0] CMIN = SAT_MIN[COORD_W-1:0];

  logic [6:0] cnt_r, cnt_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) cnt_nxt = cnt_r + 1'b1;
    else if (out_acc && !in_acc) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mapped_x) && $stable(out_mapped_y)
                                && $stable(out_status))
    else $error("output payload changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> cnt_r != '0)
    else $error("result delivered without an outstanding transaction");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |->
      out_mapped_x == CMAX || out_mapped_x == CMIN ||
      out_mapped_y == CMAX || out_mapped_y == CMIN)
    else $error("saturated status without a clamped coordinate");

endmodule

bind reference_element_affine_map ream_checker u_ream_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_mapped_x (out_ch.mapped_x),
  .out_mapped_y (out_ch.mapped_y),
  .out_status   (out_ch.status)
);

### tb/reference_element_affine_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reference_element_affine_map_checker
// Watches both channels of the affine map, predicts each mapped point from
// the accepted input transaction and compares the results in order.
// ----------------------------------------------------------------------------
module reference_element_affine_map_checker (
  input  logic clk,
  input  logic rst_n,
  ream_in_if   in_ch,
  ream_out_if  out_ch,
  output int   failures,
  output int   pending,
  output int   points_mapped
);
  import ream_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    status_t                   st;
  } mapped_pt_t;

  mapped_pt_t mapped_q[$];

  initial begin
    failures      = 0;
    points_mapped = 0;
  end

  assign pending = mapped_q.size();

  function automatic logic signed [COORD_W-1:0] clamp(wide_t v, inout logic clipped);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (COORD_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (COORD_W - 1));
    if (v > hi) begin
      clipped = 1'b1;
      return hi[COORD_W-1:0];
    end
    if (v < lo) begin
      clipped = 1'b1;
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  // Affine map of one point, with exact 128-bit intermediates.
  function automatic mapped_pt_t map_point(logic cmd, logic [2:0] kind,
      logic signed [COORD_W-1:0] px_i, py_i, x0_i, y0_i, x1_i, y1_i,
      x2_i, y2_i, y3_i);
    mapped_pt_t r;
    wide_t px, py, x0, y0, x1, y1, x2, y2, y3;
    wide_t one, rx, ry, a, b, c, d, det;
    logic  clipped;
    px = px_i; py = py_i; x0 = x0_i; y0 = y0_i; x1 = x1_i;
    y1 = y1_i; x2 = x2_i; y2 = y2_i; y3 = y3_i;
    one = wide_t'(1) <<< FRAC_BITS;
    rx = px;
    ry = py;
    r.st = ST_OK;
    clipped = 1'b0;
    if (kind == KIND_RECT) begin
      a = x1 - x0;
      d = y3 - y0;
      if (cmd == CMD_G2L) begin
        if (a == 0 || d == 0) begin
          r.st = ST_DEGEN;
        end else begin
          rx = (((px - x0) <<< (FRAC_BITS + 1)) / a) - one;
          ry = (((py - y0) <<< (FRAC_BITS + 1)) / d) - one;
        end
      end else begin
        rx = x0 + ((a * (px + one)) >>> (FRAC_BITS + 1));
        ry = y0 + ((d * (py + one)) >>> (FRAC_BITS + 1));
      end
    end else if (kind == KIND_TRI) begin
      a = x1 - x0;
      b = x2 - x0;
      c = y1 - y0;
      d = y2 - y0;
      if (cmd == CMD_G2L) begin
        det = a * d - b * c;
        if (det == 0) begin
          r.st = ST_DEGEN;
        end else begin
          // Inverse through the adjugate [[d, -b], [-c, a]].
          rx = ((d * (px - x0) - b * (py - y0)) <<< FRAC_BITS) / det;
          ry = ((a * (py - y0) - c * (px - x0)) <<< FRAC_BITS) / det;
        end
      end else begin
        rx = x0 + ((px * a + py * b) >>> FRAC_BITS);
        ry = y0 + ((px * c + py * d) >>> FRAC_BITS);
      end
    end else begin
      r.st = ST_UNKNOWN;
    end
    if (r.st != ST_OK) begin
      r.mx = px_i;
      r.my = py_i;
    end else begin
      r.mx = clamp(rx, clipped);
      r.my = clamp(ry, clipped);
      if (clipped) r.st = ST_SAT;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    failures++;
  endtask

  always @(posedge clk) begin
    mapped_pt_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        mapped_q.push_back(map_point(in_ch.cmd, in_ch.cell_kind, in_ch.point_x,
          in_ch.point_y, in_ch.node0_x, in_ch.node0_y, in_ch.node1_x, in_ch.node1_y,
          in_ch.node2_x, in_ch.node2_y, in_ch.node3_y));
      end
      if (out_ch.valid && out_ch.ready) begin
        points_mapped++;
        if (mapped_q.size() == 0) begin
          $display("%0t result transaction with no point waiting", $time);
          failures++;
        end else begin
          want = mapped_q.pop_front();
          if (out_ch.mapped_x !== want.mx) report_mismatch("mapped_x", want.mx, out_ch.mapped_x);
          if (out_ch.mapped_y !== want.my) report_mismatch("mapped_y", want.my, out_ch.mapped_y);
          if (out_ch.status !== want.st) report_mismatch("status", want.st, out_ch.status);
        end
      end
    end
  end

endmodule

### tb/reference_element_affine_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reference_element_affine_map_test
// Drives points in both directions through rectangle, triangle and unknown
// cells, with random idling and back pressure, and reports the verdict.
// ----------------------------------------------------------------------------
module reference_element_affine_map_test;
  import ream_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int FIX_ONE     = 1 << FRAC_BITS;

  typedef struct {
    logic                      cmd;
    logic [2:0]                kind;
    logic signed [COORD_W-1:0] px, py, x0, y0, x1, y1, x2, y2, y3;
  } map_req_t;

  logic clk;
  logic rst_n;
  int   failures;
  int   pending;
  int   points_mapped;
  int   points_sent;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  bit   hold_req;
  int   quiet_cycles;

  ream_in_if  in_ch ();
  ream_out_if out_ch ();

  reference_element_affine_map uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  reference_element_affine_map_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .failures      (failures),
    .pending       (pending),
    .points_mapped (points_mapped)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // The receiver either stalls at random or, when asked, holds off for a long
  // stretch of its own, so that the queue in the block fills and input stalls.
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any run with this many cycles and no transaction is stuck.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A random signed value in [-span, span].
  function automatic logic signed [COORD_W-1:0] near(int unsigned span);
    return $signed($urandom_range(2 * span)) - $signed(span);
  endfunction

  // One input transaction: drive at the falling edge, hold until accepted.
  task automatic send(map_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= r.cmd;
    in_ch.cell_kind <= r.kind;
    in_ch.point_x   <= r.px;
    in_ch.point_y   <= r.py;
    in_ch.node0_x   <= r.x0;
    in_ch.node0_y   <= r.y0;
    in_ch.node1_x   <= r.x1;
    in_ch.node1_y   <= r.y1;
    in_ch.node2_x   <= r.x2;
    in_ch.node2_y   <= r.y2;
    in_ch.node3_y   <= r.y3;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    points_sent++;
  endtask

  // The sender stops offering and waits for every point to come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  function automatic map_req_t make_point(logic cmd, logic [2:0] kind,
      int px, int py, int x0, int y0, int x1, int y1, int x2, int y2, int y3);
    map_req_t r;
    r.cmd = cmd; r.kind = kind; r.px = px; r.py = py; r.x0 = x0; r.y0 = y0;
    r.x1 = x1; r.y1 = y1; r.x2 = x2; r.y2 = y2; r.y3 = y3;
    return r;
  endfunction

  // Random cell and point. Most are plausible mesh cells with the point near
  // the cell, some are degenerate, some are raw bit patterns.
  function automatic map_req_t random_point();
    map_req_t r;
    int       shape;
    int       w;
    int       h;
    shape = $urandom_range(99);
    r.cmd = 1'($urandom_range(1));
    r.kind = (shape < 45) ? KIND_RECT : (shape < 90) ? KIND_TRI : 3'($urandom_range(7));
    r.x0 = near(200 * FIX_ONE);
    r.y0 = near(200 * FIX_ONE);
    w = near(8 * FIX_ONE);
    h = near(8 * FIX_ONE);
    r.x1 = r.x0 + w;
    r.y1 = r.y0 + near(8 * FIX_ONE);
    r.x2 = r.x0 + near(8 * FIX_ONE);
    r.y2 = r.y0 + h;
    r.y3 = r.y0 + h;
    if (r.cmd == CMD_L2G) begin
      r.px = near(3 * FIX_ONE / 2);
      r.py = near(3 * FIX_ONE / 2);
    end else begin
      r.px = r.x0 + near(10 * FIX_ONE);
      r.py = r.y0 + near(10 * FIX_ONE);
    end
    case ($urandom_range(9))
      0: begin
        // Collapsed cell: zero width, zero height or collinear nodes.
        if ($urandom_range(1)) r.x1 = r.x0;
        else r.y3 = r.y0;
        r.x2 = r.x0 + 2 * (r.x1 - r.x0);
        r.y2 = r.y0 + 2 * (r.y1 - r.y0);
      end
      1, 2: begin
        r.px = $urandom; r.py = $urandom; r.x0 = $urandom; r.y0 = $urandom;
        r.x1 = $urandom; r.y1 = $urandom; r.x2 = $urandom; r.y2 = $urandom;
        r.y3 = $urandom;
      end
      3: begin
        // Tiny cell, so the local coordinates run out of range.
        r.x1 = r.x0 + $urandom_range(1, 3);
        r.y3 = r.y0 - $urandom_range(1, 3);
        r.y2 = r.y3;
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    map_req_t dir_q[$];
    int       phase_idle[4];
    int       phase_stall[4];
    int       max_c;
    int       min_c;
    phase_idle  = '{0, 79, 0, 9};
    phase_stall = '{0, 0, 79, 9};
    max_c = 32'h7fff_ffff;
    min_c = 32'h8000_0000;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_G2L;
    in_ch.cell_kind = KIND_RECT;
    {in_ch.point_x, in_ch.point_y, in_ch.node0_x, in_ch.node0_y, in_ch.node1_x}
      = '0;
    {in_ch.node1_y, in_ch.node2_x, in_ch.node2_y, in_ch.node3_y} = '0;
    points_sent    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    hold_req       = 1'b0;
    quiet_cycles   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unit cells both ways, the unknown kinds, collapsed cells,
    // saturation through tiny and huge cells, and the field extremes.
    dir_q.push_back(make_point(CMD_G2L, KIND_RECT, FIX_ONE / 2, FIX_ONE / 4,
      0, 0, FIX_ONE, 0, 0, 0, FIX_ONE));
    dir_q.push_back(make_point(CMD_L2G, KIND_RECT, -FIX_ONE, FIX_ONE,
      0, 0, FIX_ONE, 0, 0, 0, FIX_ONE));
    dir_q.push_back(make_point(CMD_G2L, KIND_TRI, FIX_ONE / 3, FIX_ONE / 3,
      0, 0, FIX_ONE, 0, 0, FIX_ONE, 0));
    dir_q.push_back(make_point(CMD_L2G, KIND_TRI, FIX_ONE / 3, -FIX_ONE / 3,
      FIX_ONE, -FIX_ONE, -FIX_ONE, 2 * FIX_ONE, 3 * FIX_ONE, FIX_ONE, 0));
    dir_q.push_back(make_point(CMD_G2L, 3'd0, max_c, min_c, 1, 2, 3, 4, 5, 6, 7));
    dir_q.push_back(make_point(CMD_L2G, 3'd7, min_c, max_c, 1, 2, 3, 4, 5, 6, 7));
    dir_q.push_back(make_point(CMD_G2L, 3'd5, -1, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(make_point(CMD_G2L, KIND_RECT, 5, 5, 7, 0, 7, 0, 0, 0, 9));
    dir_q.push_back(make_point(CMD_G2L, KIND_RECT, 5, 5, 0, 3, 9, 0, 0, 0, 3));
    dir_q.push_back(make_point(CMD_G2L, KIND_TRI, 5, 5, 0, 0, 4, 4, 8, 8, 0));
    dir_q.push_back(make_point(CMD_L2G, KIND_RECT, 5, 5, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(make_point(CMD_G2L, KIND_RECT, max_c, min_c, 0, 0, 1, 0, 0, 0, 1));
    dir_q.push_back(make_point(CMD_G2L, KIND_RECT, min_c, max_c, max_c, min_c,
      min_c, 0, 0, 0, max_c));
    dir_q.push_back(make_point(CMD_L2G, KIND_RECT, max_c, max_c, min_c, min_c,
      max_c, 0, 0, 0, max_c));
    dir_q.push_back(make_point(CMD_L2G, KIND_TRI, max_c, min_c, min_c, max_c,
      max_c, min_c, min_c, max_c, 0));
    dir_q.push_back(make_point(CMD_G2L, KIND_TRI, max_c, min_c, min_c, min_c,
      min_c + 1, min_c, min_c, min_c + 1, 0));
    dir_q.push_back(make_point(CMD_G2L, KIND_TRI, min_c, max_c, 0, 0, 1, 0, 0, -1, 0));
    dir_q.push_back(make_point(CMD_G2L, KIND_RECT, -3 * FIX_ONE, 7 * FIX_ONE,
      2 * FIX_ONE, FIX_ONE, -2 * FIX_ONE, 0, 0, 0, -FIX_ONE));
    dir_q.push_back(make_point(CMD_L2G, KIND_TRI, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    dir_q.push_back(make_point(CMD_G2L, KIND_TRI, -1, -1, 0, 0, max_c, 0, 0, max_c, 0));
    foreach (dir_q[i]) send(dir_q[i]);
    drain();

    // Random phases with different idling and stall mixes; the first also has a long
    // receiver hold-off while the sender keeps offering points.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < 263; n++) send(random_point());
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (80) @(posedge clk);
    $display("Mapped %0d of %0d points: rectangles, triangles and unknown cells,",
      points_mapped, points_sent);
    $display("both directions, collapsed and saturating cells, under idle and stall.");
    if (failures == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
